// ----- src/rv32d_pkg.sv -----
package rv32d_pkg;

   localparam logic [6:0] OPC_R      = 7'h33;
   localparam logic [6:0] OPC_I      = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYS    = 7'h73;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_MEXT = 7'h01;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   localparam logic [2:0] F3_0 = 3'd0;
   localparam logic [2:0] F3_1 = 3'd1;
   localparam logic [2:0] F3_2 = 3'd2;
   localparam logic [2:0] F3_3 = 3'd3;
   localparam logic [2:0] F3_4 = 3'd4;
   localparam logic [2:0] F3_5 = 3'd5;
   localparam logic [2:0] F3_6 = 3'd6;
   localparam logic [2:0] F3_7 = 3'd7;

   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

   localparam int OP_W  = 6;
   localparam int REG_W = 5;
   localparam int IMM_W = 21;

   typedef enum logic [OP_W-1:0] {
      OP_ADD, OP_MUL, OP_SUB, OP_SLL, OP_MULH, OP_SLT, OP_SLTU, OP_MULHU,
      OP_XOR, OP_DIV, OP_SRL, OP_DIVU, OP_SRA, OP_OR, OP_REM, OP_AND,
      OP_REMU, OP_ADDI, OP_JALR, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI,
      OP_SRLI, OP_SRAI, OP_ORI, OP_ANDI, OP_LB, OP_LH, OP_LW, OP_LBU,
      OP_LHU, OP_SB, OP_SH, OP_SW, OP_BEQ, OP_BNE, OP_BLT, OP_BGE,
      OP_BLTU, OP_BGEU, OP_LUI, OP_AUIPC, OP_JAL, OP_ECALL
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [REG_W-1:0]         rd;
      logic [REG_W-1:0]         rs1;
      logic [REG_W-1:0]         rs2;
      logic signed [IMM_W-1:0]  imm;
      logic                     illegal;
   } dec_type;

endpackage

// ----- src/rv32d_decode.sv -----
module rv32d_decode (
   input  logic [31:0]       word,
   output rv32d_pkg::dec_type dec
);

   logic [6:0] opc;
   logic [2:0] f3;
   logic [6:0] f7;
   logic       hit;
   rv32d_pkg::op_type        op;
   logic [4:0]               rd;
   logic [4:0]               rs1;
   logic [4:0]               rs2;
   logic signed [20:0]       imm;
   logic signed [20:0]       imm_i;
   logic signed [20:0]       imm_s;
   logic signed [20:0]       imm_b;
   logic signed [20:0]       imm_j;
   logic signed [20:0]       imm_u;
   logic signed [20:0]       imm_sh;

   assign opc = word[6:0];
   assign f3  = word[14:12];
   assign f7  = word[31:25];

   assign imm_i  = {{9{word[31]}}, word[31:20]};
   assign imm_s  = {{9{word[31]}}, word[31:25], word[11:7]};
   assign imm_b  = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
   assign imm_j  = {word[31], word[19:12], word[20], word[30:21], 1'b0};
   assign imm_u  = {1'b0, word[31:12]};
   assign imm_sh = {16'd0, word[24:20]};

   always_comb begin
      hit = 1'b1;
      op  = rv32d_pkg::OP_ADD;
      rd  = '0;
      rs1 = '0;
      rs2 = '0;
      imm = '0;
      case (opc)
         rv32d_pkg::OPC_R: begin
            rd  = word[11:7];
            rs1 = word[19:15];
            rs2 = word[24:20];
            if (f7 == rv32d_pkg::F7_BASE) begin
               case (f3)
                  rv32d_pkg::F3_0: op = rv32d_pkg::OP_ADD;
                  rv32d_pkg::F3_1: op = rv32d_pkg::OP_SLL;
                  rv32d_pkg::F3_2: op = rv32d_pkg::OP_SLT;
                  rv32d_pkg::F3_3: op = rv32d_pkg::OP_SLTU;
                  rv32d_pkg::F3_4: op = rv32d_pkg::OP_XOR;
                  rv32d_pkg::F3_5: op = rv32d_pkg::OP_SRL;
                  rv32d_pkg::F3_6: op = rv32d_pkg::OP_OR;
                  default:         op = rv32d_pkg::OP_AND;
               endcase
            end else if (f7 == rv32d_pkg::F7_MEXT) begin
               case (f3)
                  rv32d_pkg::F3_0: op = rv32d_pkg::OP_MUL;
                  rv32d_pkg::F3_1: op = rv32d_pkg::OP_MULH;
                  rv32d_pkg::F3_3: op = rv32d_pkg::OP_MULHU;
                  rv32d_pkg::F3_4: op = rv32d_pkg::OP_DIV;
                  rv32d_pkg::F3_5: op = rv32d_pkg::OP_DIVU;
                  rv32d_pkg::F3_6: op = rv32d_pkg::OP_REM;
                  rv32d_pkg::F3_7: op = rv32d_pkg::OP_REMU;
                  default:         hit = 1'b0;
               endcase
            end else if (f7 == rv32d_pkg::F7_ALT) begin
               case (f3)
                  rv32d_pkg::F3_0: op = rv32d_pkg::OP_SUB;
                  rv32d_pkg::F3_5: op = rv32d_pkg::OP_SRA;
                  default:         hit = 1'b0;
               endcase
            end else begin
               hit = 1'b0;
            end
         end
         rv32d_pkg::OPC_I: begin
            rd  = word[11:7];
            rs1 = word[19:15];
            imm = imm_i;
            case (f3)
               rv32d_pkg::F3_0: op = rv32d_pkg::OP_ADDI;
               rv32d_pkg::F3_1: begin
                  imm = imm_sh;
                  op  = rv32d_pkg::OP_SLLI;
                  hit = (f7 == rv32d_pkg::F7_BASE);
               end
               rv32d_pkg::F3_2: op = rv32d_pkg::OP_SLTI;
               rv32d_pkg::F3_3: op = rv32d_pkg::OP_SLTIU;
               rv32d_pkg::F3_4: op = rv32d_pkg::OP_XORI;
               rv32d_pkg::F3_5: begin
                  imm = imm_sh;
                  if (f7 == rv32d_pkg::F7_BASE) begin
                     op = rv32d_pkg::OP_SRLI;
                  end else if (f7 == rv32d_pkg::F7_ALT) begin
                     op = rv32d_pkg::OP_SRAI;
                  end else begin
                     hit = 1'b0;
                  end
               end
               rv32d_pkg::F3_6: op = rv32d_pkg::OP_ORI;
               default:         op = rv32d_pkg::OP_ANDI;
            endcase
         end
         rv32d_pkg::OPC_JALR: begin
            rd  = word[11:7];
            rs1 = word[19:15];
            imm = imm_i;
            op  = rv32d_pkg::OP_JALR;
            hit = (f3 == rv32d_pkg::F3_0);
         end
         rv32d_pkg::OPC_LOAD: begin
            rd  = word[11:7];
            rs1 = word[19:15];
            imm = imm_i;
            case (f3)
               rv32d_pkg::F3_0: op = rv32d_pkg::OP_LB;
               rv32d_pkg::F3_1: op = rv32d_pkg::OP_LH;
               rv32d_pkg::F3_2: op = rv32d_pkg::OP_LW;
               rv32d_pkg::F3_4: op = rv32d_pkg::OP_LBU;
               rv32d_pkg::F3_5: op = rv32d_pkg::OP_LHU;
               default:         hit = 1'b0;
            endcase
         end
         rv32d_pkg::OPC_STORE: begin
            rs1 = word[19:15];
            rs2 = word[24:20];
            imm = imm_s;
            case (f3)
               rv32d_pkg::F3_0: op = rv32d_pkg::OP_SB;
               rv32d_pkg::F3_1: op = rv32d_pkg::OP_SH;
               rv32d_pkg::F3_2: op = rv32d_pkg::OP_SW;
               default:         hit = 1'b0;
            endcase
         end
         rv32d_pkg::OPC_BRANCH: begin
            rs1 = word[19:15];
            rs2 = word[24:20];
            imm = imm_b;
            case (f3)
               rv32d_pkg::F3_0: op = rv32d_pkg::OP_BEQ;
               rv32d_pkg::F3_1: op = rv32d_pkg::OP_BNE;
               rv32d_pkg::F3_4: op = rv32d_pkg::OP_BLT;
               rv32d_pkg::F3_5: op = rv32d_pkg::OP_BGE;
               rv32d_pkg::F3_6: op = rv32d_pkg::OP_BLTU;
               rv32d_pkg::F3_7: op = rv32d_pkg::OP_BGEU;
               default:         hit = 1'b0;
            endcase
         end
         rv32d_pkg::OPC_LUI: begin
            rd  = word[11:7];
            imm = imm_u;
            op  = rv32d_pkg::OP_LUI;
         end
         rv32d_pkg::OPC_AUIPC: begin
            rd  = word[11:7];
            imm = imm_u;
            op  = rv32d_pkg::OP_AUIPC;
         end
         rv32d_pkg::OPC_JAL: begin
            rd  = word[11:7];
            imm = imm_j;
            op  = rv32d_pkg::OP_JAL;
         end
         rv32d_pkg::OPC_SYS: begin
            op  = rv32d_pkg::OP_ECALL;
            hit = (word == rv32d_pkg::ECALL_WORD);
         end
         default: hit = 1'b0;
      endcase
   end

   // illegal words report op, rd, rs1, rs2 and imm all zero
   always_comb begin
      if (hit) begin
         dec.op      = op;
         dec.rd      = rd;
         dec.rs1     = rs1;
         dec.rs2     = rs2;
         dec.imm     = imm;
         dec.illegal = 1'b0;
      end else begin
         dec.op      = rv32d_pkg::OP_ADD;
         dec.rd      = '0;
         dec.rs1     = '0;
         dec.rs2     = '0;
         dec.imm     = '0;
         dec.illegal = 1'b1;
      end
   end

endmodule

// ----- src/rv32im_instruction_decoder.sv -----
// Two registers lie between req and rsp (input register, result register); rsp_tvalid rises
// once a taken transaction has passed both, and a busy result register holds it in the input one.
// Throughput: one instruction per cycle; the two-entry pipeline keeps accepting
// while a result waits, as long as a stage is free to advance.
// Reset: synchronous, active high; clears both stage valid bits, payload is not reset.
// Decode between the registers is a single combinational pass.
module rv32im_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instr_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] op, [10:6] rd, [15:11] rs1, [20:16] rs2,
                                    // [41:21] imm, [47:42] zero
   output logic [0:0]  rsp_tuser    // [0] illegal
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [31:0]        in_word_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   rv32d_pkg::dec_type out_dec_ff;
   rv32d_pkg::dec_type dec;
   logic               out_free;
   logic               in_move;
   logic               req_take;

   rv32d_decode u_decode (
      .word (in_word_ff),
      .dec  (dec)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_move    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = in_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_tdata;
      end
      if (in_move) begin
         out_dec_ff <= dec;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_dec_ff.imm, out_dec_ff.rs2, out_dec_ff.rs1,
                        out_dec_ff.rd, out_dec_ff.op};
   assign rsp_tuser  = out_dec_ff.illegal;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 48'd0))
      else $error("illegal result carries nonzero fields");

   a_op_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] <= 6'd44))
      else $error("op out of range");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted transaction lost in input stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input stage changed during stall");

endmodule

// ----- bench/rv32im_instruction_decoder_test.sv -----
module rv32im_instruction_decoder_test;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_COUNT = 393;

   typedef struct {
      logic [31:0]        instr;
      rv32d_pkg::dec_type dec;
   } pending_decode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] instr_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [5:0] op, [10:6] rd, [15:11] rs1, [20:16] rs2,
                                  // [41:21] imm, [47:42] zero
   logic [0:0]  rsp_tuser;        // [0] illegal

   pending_decode_type expected_decodes[$];
   int error_count = 0;
   int stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   rv32im_instruction_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic rv32d_pkg::dec_type decode_instr(input logic [31:0] instr);
      rv32d_pkg::dec_type r;
      rv32d_pkg::op_type  code;
      bit                 ok;
      logic [2:0]         f3;
      logic [6:0]         f7;
      r = '0;
      code = rv32d_pkg::OP_ADD;
      ok = 1'b1;
      f3 = instr[14:12];
      f7 = instr[31:25];
      case (instr[6:0])
         rv32d_pkg::OPC_R: begin
            r.rd = instr[11:7];
            r.rs1 = instr[19:15];
            r.rs2 = instr[24:20];
            if (f7 == rv32d_pkg::F7_BASE) begin
               case (f3)
                  rv32d_pkg::F3_0: code = rv32d_pkg::OP_ADD;
                  rv32d_pkg::F3_1: code = rv32d_pkg::OP_SLL;
                  rv32d_pkg::F3_2: code = rv32d_pkg::OP_SLT;
                  rv32d_pkg::F3_3: code = rv32d_pkg::OP_SLTU;
                  rv32d_pkg::F3_4: code = rv32d_pkg::OP_XOR;
                  rv32d_pkg::F3_5: code = rv32d_pkg::OP_SRL;
                  rv32d_pkg::F3_6: code = rv32d_pkg::OP_OR;
                  default: code = rv32d_pkg::OP_AND;
               endcase
            end else if (f7 == rv32d_pkg::F7_MEXT) begin
               case (f3)
                  rv32d_pkg::F3_0: code = rv32d_pkg::OP_MUL;
                  rv32d_pkg::F3_1: code = rv32d_pkg::OP_MULH;
                  rv32d_pkg::F3_3: code = rv32d_pkg::OP_MULHU;
                  rv32d_pkg::F3_4: code = rv32d_pkg::OP_DIV;
                  rv32d_pkg::F3_5: code = rv32d_pkg::OP_DIVU;
                  rv32d_pkg::F3_6: code = rv32d_pkg::OP_REM;
                  rv32d_pkg::F3_7: code = rv32d_pkg::OP_REMU;
                  default: ok = 1'b0;   // mulhsu unsupported
               endcase
            end else if (f7 == rv32d_pkg::F7_ALT && f3 == rv32d_pkg::F3_0) begin
               code = rv32d_pkg::OP_SUB;
            end else if (f7 == rv32d_pkg::F7_ALT && f3 == rv32d_pkg::F3_5) begin
               code = rv32d_pkg::OP_SRA;
            end else begin
               ok = 1'b0;
            end
         end
         rv32d_pkg::OPC_I: begin
            r.rd = instr[11:7];
            r.rs1 = instr[19:15];
            r.imm = {{9{instr[31]}}, instr[31:20]};
            case (f3)
               rv32d_pkg::F3_0: code = rv32d_pkg::OP_ADDI;
               rv32d_pkg::F3_1: begin
                  r.imm = {16'b0, instr[24:20]};
                  if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::OP_SLLI;
                  else ok = 1'b0;
               end
               rv32d_pkg::F3_2: code = rv32d_pkg::OP_SLTI;
               rv32d_pkg::F3_3: code = rv32d_pkg::OP_SLTIU;
               rv32d_pkg::F3_4: code = rv32d_pkg::OP_XORI;
               rv32d_pkg::F3_5: begin
                  r.imm = {16'b0, instr[24:20]};
                  if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::OP_SRLI;
                  else if (f7 == rv32d_pkg::F7_ALT) code = rv32d_pkg::OP_SRAI;
                  else ok = 1'b0;
               end
               rv32d_pkg::F3_6: code = rv32d_pkg::OP_ORI;
               default: code = rv32d_pkg::OP_ANDI;
            endcase
         end
         rv32d_pkg::OPC_JALR: begin
            r.rd = instr[11:7];
            r.rs1 = instr[19:15];
            r.imm = {{9{instr[31]}}, instr[31:20]};
            if (f3 == rv32d_pkg::F3_0) code = rv32d_pkg::OP_JALR;
            else ok = 1'b0;
         end
         rv32d_pkg::OPC_LOAD: begin
            r.rd = instr[11:7];
            r.rs1 = instr[19:15];
            r.imm = {{9{instr[31]}}, instr[31:20]};
            case (f3)
               rv32d_pkg::F3_0: code = rv32d_pkg::OP_LB;
               rv32d_pkg::F3_1: code = rv32d_pkg::OP_LH;
               rv32d_pkg::F3_2: code = rv32d_pkg::OP_LW;
               rv32d_pkg::F3_4: code = rv32d_pkg::OP_LBU;
               rv32d_pkg::F3_5: code = rv32d_pkg::OP_LHU;
               default: ok = 1'b0;
            endcase
         end
         rv32d_pkg::OPC_STORE: begin
            r.rs1 = instr[19:15];
            r.rs2 = instr[24:20];
            r.imm = {{9{instr[31]}}, instr[31:25], instr[11:7]};
            case (f3)
               rv32d_pkg::F3_0: code = rv32d_pkg::OP_SB;
               rv32d_pkg::F3_1: code = rv32d_pkg::OP_SH;
               rv32d_pkg::F3_2: code = rv32d_pkg::OP_SW;
               default: ok = 1'b0;
            endcase
         end
         rv32d_pkg::OPC_BRANCH: begin
            r.rs1 = instr[19:15];
            r.rs2 = instr[24:20];
            r.imm = {{8{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
            case (f3)
               rv32d_pkg::F3_0: code = rv32d_pkg::OP_BEQ;
               rv32d_pkg::F3_1: code = rv32d_pkg::OP_BNE;
               rv32d_pkg::F3_4: code = rv32d_pkg::OP_BLT;
               rv32d_pkg::F3_5: code = rv32d_pkg::OP_BGE;
               rv32d_pkg::F3_6: code = rv32d_pkg::OP_BLTU;
               rv32d_pkg::F3_7: code = rv32d_pkg::OP_BGEU;
               default: ok = 1'b0;
            endcase
         end
         rv32d_pkg::OPC_LUI, rv32d_pkg::OPC_AUIPC: begin
            code = (instr[6:0] == rv32d_pkg::OPC_LUI) ? rv32d_pkg::OP_LUI
                                                       : rv32d_pkg::OP_AUIPC;
            r.rd = instr[11:7];
            r.imm = {1'b0, instr[31:12]};
         end
         rv32d_pkg::OPC_JAL: begin
            code = rv32d_pkg::OP_JAL;
            r.rd = instr[11:7];
            r.imm = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
         end
         rv32d_pkg::OPC_SYS: begin
            if (instr == rv32d_pkg::ECALL_WORD) code = rv32d_pkg::OP_ECALL;
            else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase
      r.op = code;
      if (!ok) begin
         r = '0;
         r.illegal = 1'b1;
      end
      return r;
   endfunction

   // mostly legal: known opcode, funct7 biased toward the decoded values
   function automatic logic [31:0] shaped_instr();
      logic [31:0] instr;
      instr = $urandom;
      case ($urandom_range(9))
         0: instr[6:0] = rv32d_pkg::OPC_R;
         1: instr[6:0] = rv32d_pkg::OPC_I;
         2: instr[6:0] = rv32d_pkg::OPC_LOAD;
         3: instr[6:0] = rv32d_pkg::OPC_JALR;
         4: instr[6:0] = rv32d_pkg::OPC_STORE;
         5: instr[6:0] = rv32d_pkg::OPC_BRANCH;
         6: instr[6:0] = rv32d_pkg::OPC_LUI;
         7: instr[6:0] = rv32d_pkg::OPC_AUIPC;
         8: instr[6:0] = rv32d_pkg::OPC_JAL;
         default: instr = rv32d_pkg::ECALL_WORD;
      endcase
      if (instr != rv32d_pkg::ECALL_WORD) begin
         case ($urandom_range(3))
            0: instr[31:25] = rv32d_pkg::F7_BASE;
            1: instr[31:25] = rv32d_pkg::F7_MEXT;
            2: instr[31:25] = rv32d_pkg::F7_ALT;
            default: ;
         endcase
      end
      return instr;
   endfunction

   function automatic logic [31:0] instr_for_op(input rv32d_pkg::op_type op);
      logic [31:0]        instr;
      rv32d_pkg::dec_type d;
      do begin
         instr = shaped_instr();
         d = decode_instr(instr);
      end while (d.illegal || d.op != op);
      return instr;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] instr,
                                  input logic [31:0] want, input logic [31:0] got);
      $display("mismatch %s: instr %h expected %h got %h", what, instr, want, got);
      error_count++;
   endtask

   task automatic send_instr(input logic [31:0] instr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = $urandom;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = instr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_decodes.push_back('{instr, decode_instr(instr)});
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_decode
      pending_decode_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch("unexpected transaction", 32'h0, 32'h0, rsp_tdata[31:0]);
         end else begin
            exp = expected_decodes.pop_front();
            if (rsp_tdata[5:0] !== exp.dec.op)
               report_mismatch("op", exp.instr, 32'(exp.dec.op), 32'(rsp_tdata[5:0]));
            if (rsp_tdata[10:6] !== exp.dec.rd)
               report_mismatch("rd", exp.instr, 32'(exp.dec.rd), 32'(rsp_tdata[10:6]));
            if (rsp_tdata[15:11] !== exp.dec.rs1)
               report_mismatch("rs1", exp.instr, 32'(exp.dec.rs1), 32'(rsp_tdata[15:11]));
            if (rsp_tdata[20:16] !== exp.dec.rs2)
               report_mismatch("rs2", exp.instr, 32'(exp.dec.rs2), 32'(rsp_tdata[20:16]));
            if (rsp_tdata[41:21] !== exp.dec.imm)
               report_mismatch("imm", exp.instr, {11'b0, exp.dec.imm},
                               {11'b0, rsp_tdata[41:21]});
            if (rsp_tdata[47:42] !== 6'b0)
               report_mismatch("pad", exp.instr, 32'h0, 32'(rsp_tdata[47:42]));
            if (rsp_tuser[0] !== exp.dec.illegal)
               report_mismatch("illegal", exp.instr, 32'(exp.dec.illegal),
                               32'(rsp_tuser[0]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_special_words();
      send_instr(32'h0000_0000);
      send_instr(32'hFFFF_FFFF);
      send_instr(rv32d_pkg::ECALL_WORD);
      send_instr(32'h0010_0073);                                    // ebreak
      send_instr({rv32d_pkg::F7_BASE, 5'd31, 5'd31, rv32d_pkg::F3_0, 5'd31, rv32d_pkg::OPC_R});
      send_instr({rv32d_pkg::F7_MEXT, 5'd1, 5'd2, rv32d_pkg::F3_2, 5'd3,
                  rv32d_pkg::OPC_R});                               // mulhsu
      send_instr({rv32d_pkg::F7_ALT, 5'd4, 5'd5, rv32d_pkg::F3_1, 5'd6, rv32d_pkg::OPC_R});
      send_instr({7'h7F, 5'd7, 5'd8, rv32d_pkg::F3_0, 5'd9, rv32d_pkg::OPC_R});
      send_instr({12'h7FF, 5'd31, rv32d_pkg::F3_0, 5'd31, rv32d_pkg::OPC_I});
      send_instr({12'h800, 5'd0, rv32d_pkg::F3_7, 5'd0, rv32d_pkg::OPC_I});
      send_instr({rv32d_pkg::F7_ALT, 5'd31, 5'd1, rv32d_pkg::F3_1, 5'd2, rv32d_pkg::OPC_I});
      send_instr({rv32d_pkg::F7_ALT, 5'd31, 5'd31, rv32d_pkg::F3_5, 5'd31, rv32d_pkg::OPC_I});
      send_instr({rv32d_pkg::F7_MEXT, 5'd31, 5'd3, rv32d_pkg::F3_5, 5'd4, rv32d_pkg::OPC_I});
      send_instr({12'hFFF, 5'd31, rv32d_pkg::F3_1, 5'd31, rv32d_pkg::OPC_JALR});
      send_instr({12'hFFF, 5'd31, rv32d_pkg::F3_0, 5'd31, rv32d_pkg::OPC_JALR});
      send_instr({12'h800, 5'd10, rv32d_pkg::F3_3, 5'd11, rv32d_pkg::OPC_LOAD});
      send_instr({12'h800, 5'd31, rv32d_pkg::F3_2, 5'd31, rv32d_pkg::OPC_LOAD});
      send_instr({7'h7F, 5'd31, 5'd31, rv32d_pkg::F3_3, 5'd31, rv32d_pkg::OPC_STORE});
      send_instr({7'h7F, 5'd31, 5'd31, rv32d_pkg::F3_2, 5'd31, rv32d_pkg::OPC_STORE});
      send_instr({7'h7F, 5'd12, 5'd13, rv32d_pkg::F3_2, 5'd31, rv32d_pkg::OPC_BRANCH});
      send_instr({7'h7F, 5'd31, 5'd31, rv32d_pkg::F3_0, 5'd31, rv32d_pkg::OPC_BRANCH});
      send_instr({7'h3F, 5'd31, 5'd31, rv32d_pkg::F3_7, 5'd31, rv32d_pkg::OPC_BRANCH});
      send_instr({20'hFFFFF, 5'd31, rv32d_pkg::OPC_LUI});
      send_instr({20'h00000, 5'd0, rv32d_pkg::OPC_AUIPC});
      send_instr({20'hFFFFF, 5'd31, rv32d_pkg::OPC_JAL});
      send_instr({1'b0, 19'h7FFFF, 5'd1, rv32d_pkg::OPC_JAL});
   endtask

   task automatic test_each_operation();
      for (int i = 0; i <= rv32d_pkg::OP_ECALL; i++)
         send_instr(instr_for_op(rv32d_pkg::op_type'(i)));
   endtask

   task automatic test_random_words(input int count);
      repeat (count) begin
         if ($urandom_range(99) < 85) send_instr(shaped_instr());
         else send_instr($urandom);
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 73;
      test_special_words();
      test_each_operation();
      test_random_words(RANDOM_COUNT);

      send_idle_pct = 73;
      recv_idle_pct = 16;
      test_random_words(RANDOM_COUNT);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_words(RANDOM_COUNT);

      req_tvalid = 1'b0;
      while (expected_decodes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
